// ===== hw/rtl/pci_pkg.sv =====
// Shared types, widths and the calibration ROM for the phase correction interpolator.
// The ROM tables are constant arrays; the base products are built at elaboration.
// No dependencies.
package pci_pkg;

  localparam int CAL_POINTS  = 21;
  localparam int SEG_W       = $clog2(CAL_POINTS);
  localparam int FREQ_W      = 24;
  localparam int MULT_W      = 8;
  localparam int CORR_W      = 14;
  localparam int DEN_W       = 13;
  localparam int NUM_W       = 26;
  localparam int U_W         = 25;
  localparam int RECIP_SHIFT = U_W;
  localparam int RECIP_W     = 14;
  localparam int Q_W         = 14;

  localparam logic [MULT_W-1:0] MULT_X1 = 8'd1;
  localparam logic [MULT_W-1:0] MULT_X2 = 8'd2;

  localparam logic [FREQ_W-1:0] CAL_FREQ [CAL_POINTS] = '{
    24'd1000,  24'd5000,  24'd10000, 24'd15000, 24'd20000, 24'd25000, 24'd30000,
    24'd35000, 24'd40000, 24'd45000, 24'd50000, 24'd55000, 24'd60000, 24'd65000,
    24'd70000, 24'd75000, 24'd80000, 24'd85000, 24'd90000, 24'd95000, 24'd100000
  };

  localparam logic signed [CORR_W-1:0] CAL_CORR1 [CAL_POINTS] = '{
    -14'sd130, 14'sd870,  14'sd1470, 14'sd1760, 14'sd2100, 14'sd2320, 14'sd2400,
    14'sd2590, 14'sd2660, 14'sd2470, 14'sd2980, 14'sd4030, 14'sd4450, 14'sd4160,
    14'sd3880, 14'sd3340, 14'sd3440, 14'sd3930, 14'sd4030, 14'sd4150, 14'sd5240
  };

  localparam logic signed [CORR_W-1:0] CAL_CORR2 [CAL_POINTS] = '{
    14'sd100,  14'sd1000, 14'sd1720, 14'sd1770, 14'sd1800, 14'sd1920, 14'sd1990,
    14'sd2120, 14'sd2280, 14'sd2310, 14'sd2540, 14'sd3170, 14'sd3560, 14'sd3360,
    14'sd3930, 14'sd3780, 14'sd4100, 14'sd4470, 14'sd4810, 14'sd4880, 14'sd4950
  };

  // Width of the segment that ends at each point; the first entry has no segment.
  localparam logic [DEN_W-1:0] CAL_DEN [CAL_POINTS] = '{
    13'd0,    13'd4000, 13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000,
    13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000,
    13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000, 13'd5000
  };

  // Reciprocal of each segment width, scaled by two to the RECIP_SHIFT and rounded down.
  localparam logic [RECIP_W-1:0] CAL_RECIP [CAL_POINTS] = '{
    14'd0,    14'd8388, 14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710,
    14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710,
    14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710, 14'd6710
  };

  typedef logic signed [NUM_W-1:0] base_tab_t [CAL_POINTS];

  // Lower correction of each segment times the segment width.
  function automatic base_tab_t build_base(input logic twice);
    base_tab_t tab;
    int        lo;
    int        prod;
    tab[0] = '0;
    for (int i = 1; i < CAL_POINTS; i++) begin
      lo     = twice ? int'(CAL_CORR2[i-1]) : int'(CAL_CORR1[i-1]);
      prod   = lo * int'(CAL_DEN[i]);
      tab[i] = NUM_W'(prod);
    end
    return tab;
  endfunction

  localparam base_tab_t CAL_BASE1 = build_base(1'b0);
  localparam base_tab_t CAL_BASE2 = build_base(1'b1);

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [SEG_W-1:0]        seg;
    logic                    rejected;
  } interp_t;

  typedef struct packed {
    logic [U_W-1:0]   mag;
    logic [Q_W-1:0]   q_est;
    logic [SEG_W-1:0] seg;
    logic             neg;
    logic             rejected;
  } quot_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correction_mdeg;
    logic                     rejected;
  } result_t;

endpackage

// ===== hw/rtl/pci_stream_if.sv =====
// Valid/ready stream interfaces for the input and result channels.
// Depends on pci_pkg for the field widths.
interface pci_in_if;
  logic                          valid;
  logic                          ready;
  logic [pci_pkg::FREQ_W-1:0]    freq_hz;
  logic [pci_pkg::MULT_W-1:0]    multiplier_select;

  modport source (output valid, freq_hz, multiplier_select, input ready);
  modport sink (input valid, freq_hz, multiplier_select, output ready);
endinterface

interface pci_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pci_pkg::CORR_W-1:0]  correction_mdeg;
  logic                               rejected;

  modport source (output valid, correction_mdeg, rejected, input ready);
  modport sink (input valid, correction_mdeg, rejected, output ready);
endinterface

// ===== hw/rtl/pci_interp.sv =====
// Segment search and interpolation numerator stage, registered at its output.
// Depends on pci_pkg for the calibration ROM and the stage struct.
module pci_interp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [pci_pkg::FREQ_W-1:0] freq_i,
  input  logic                       twice_i,
  input  logic                       rejected_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output pci_pkg::interp_t           data_o
);

  logic [pci_pkg::SEG_W-1:0]                         seg;
  logic [pci_pkg::SEG_W-1:0]                         seg_lo;
  logic                                              found;
  logic                                              below;
  logic [pci_pkg::FREQ_W-1:0]                        offset;
  logic [pci_pkg::DEN_W-1:0]                         step;
  logic signed [pci_pkg::CORR_W-1:0]                 lo;
  logic signed [pci_pkg::CORR_W-1:0]                 hi;
  logic signed [pci_pkg::CORR_W:0]                   diff;
  logic signed [pci_pkg::CORR_W+pci_pkg::DEN_W+1:0]  prod;
  logic signed [pci_pkg::NUM_W-1:0]                  base;
  logic                                              valid_r;
  pci_pkg::interp_t                                  data_r;
  pci_pkg::interp_t                                  data_nxt;

  // Out-of-range frequencies land on an end segment with a zero or full step.
  always_comb begin
    seg   = pci_pkg::SEG_W'(pci_pkg::CAL_POINTS - 1);
    found = 1'b0;
    for (int i = 1; i < pci_pkg::CAL_POINTS; i++) begin
      if (!found && freq_i <= pci_pkg::CAL_FREQ[i]) begin
        seg   = pci_pkg::SEG_W'(i);
        found = 1'b1;
      end
    end
    below = freq_i <= pci_pkg::CAL_FREQ[0];
    if (below) begin
      seg = pci_pkg::SEG_W'(1);
    end
    seg_lo = seg - pci_pkg::SEG_W'(1);
    offset = freq_i - pci_pkg::CAL_FREQ[seg_lo];
    if (below) begin
      step = '0;
    end else if (!found) begin
      step = pci_pkg::CAL_DEN[seg];
    end else begin
      step = offset[pci_pkg::DEN_W-1:0];
    end
    lo   = twice_i ? pci_pkg::CAL_CORR2[seg_lo] : pci_pkg::CAL_CORR1[seg_lo];
    hi   = twice_i ? pci_pkg::CAL_CORR2[seg] : pci_pkg::CAL_CORR1[seg];
    diff = (pci_pkg::CORR_W+1)'(hi) - (pci_pkg::CORR_W+1)'(lo);
    prod = $signed({1'b0, step}) * diff;
    base = twice_i ? pci_pkg::CAL_BASE2[seg] : pci_pkg::CAL_BASE1[seg];
    data_nxt.num      = base + pci_pkg::NUM_W'(prod);
    data_nxt.seg      = seg;
    data_nxt.rejected = rejected_i;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== hw/rtl/pci_round_div.sv =====
// Rounded division of the numerator by the segment width, in two registered stages:
// a reciprocal multiply for the quotient estimate, then a one-step correction.
// Depends on pci_pkg for the reciprocal table and the stage structs.
module pci_round_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  output logic             ready_o,
  input  pci_pkg::interp_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pci_pkg::result_t data_o
);

  localparam int PROD_W = pci_pkg::U_W + pci_pkg::RECIP_W;
  localparam int BACK_W = pci_pkg::DEN_W + pci_pkg::Q_W;

  logic                              neg;
  logic [pci_pkg::NUM_W-1:0]         abs_num;
  logic [pci_pkg::U_W-1:0]           mag;
  logic [PROD_W-1:0]                 prod;
  logic [pci_pkg::DEN_W-1:0]         den_b;
  logic [BACK_W-1:0]                 back;
  logic [BACK_W-1:0]                 rem;
  logic [pci_pkg::Q_W-1:0]           quot;
  logic signed [pci_pkg::CORR_W-1:0] cq;
  logic                              rdy_b;
  logic                              va_r;
  logic                              vb_r;
  pci_pkg::quot_t                    qa_r;
  pci_pkg::quot_t                    qa_nxt;
  pci_pkg::result_t                  res_r;
  pci_pkg::result_t                  res_nxt;

  // Halves round away from zero: add half the width to the magnitude.
  always_comb begin
    neg     = data_i.num[pci_pkg::NUM_W-1];
    abs_num = neg ? pci_pkg::NUM_W'(-data_i.num) : pci_pkg::NUM_W'(data_i.num);
    mag     = pci_pkg::U_W'(abs_num) + pci_pkg::U_W'(pci_pkg::CAL_DEN[data_i.seg] >> 1);
    prod    = PROD_W'(mag) * PROD_W'(pci_pkg::CAL_RECIP[data_i.seg]);
    qa_nxt.mag      = mag;
    qa_nxt.q_est    = prod[pci_pkg::RECIP_SHIFT +: pci_pkg::Q_W];
    qa_nxt.seg      = data_i.seg;
    qa_nxt.neg      = neg;
    qa_nxt.rejected = data_i.rejected;
  end

  // The estimate is low by at most one.
  always_comb begin
    den_b = pci_pkg::CAL_DEN[qa_r.seg];
    back  = BACK_W'(qa_r.q_est) * BACK_W'(den_b);
    rem   = BACK_W'(qa_r.mag) - back;
    quot  = (rem >= BACK_W'(den_b)) ? qa_r.q_est + pci_pkg::Q_W'(1) : qa_r.q_est;
    cq    = pci_pkg::CORR_W'(quot);
    res_nxt.rejected = qa_r.rejected;
    if (qa_r.rejected) begin
      res_nxt.correction_mdeg = '0;
    end else begin
      res_nxt.correction_mdeg = qa_r.neg ? -cq : cq;
    end
  end

  assign rdy_b   = !vb_r || ready_i;
  assign ready_o = !va_r || rdy_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_o) begin
        va_r <= valid_i;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      qa_r <= qa_nxt;
    end
    if (va_r && rdy_b) begin
      res_r <= res_nxt;
    end
  end

  assign valid_o = vb_r;
  assign data_o  = res_r;

endmodule

// ===== hw/rtl/phase_correction_interpolator.sv =====
// Phase correction interpolator: maps a reference frequency in hertz and a 1x/2x
// multiplier code to a correction in millidegrees from a 21-point calibration ROM,
// with linear interpolation between points, rounding to nearest (halves away from
// zero) and the end values held outside the table. Any multiplier other than 1 or 2
// returns zero with the rejected flag set. The block takes one beat per cycle while the
// output is not stalled; a result passes through four register ranks: input, numerator,
// quotient estimate, result. Each rank advances on its own, so input beats keep
// flowing into empty ranks while a result waits at the output. Depends on pci_pkg,
// pci_stream_if, pci_interp and pci_round_div.
module phase_correction_interpolator (
  input  logic             clk,
  input  logic             rst_n,
  pci_in_if.sink           in_s,
  pci_out_if.source        out_s
);

  logic                       v1_r;
  logic [pci_pkg::FREQ_W-1:0] freq_r;
  logic                       twice_r;
  logic                       rej_r;
  logic                       rdy1;
  logic                       v2;
  logic                       rdy2;
  pci_pkg::interp_t           interp;
  pci_pkg::result_t           result;

  assign in_s.ready = !v1_r || rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_s.ready) begin
      v1_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      freq_r  <= in_s.freq_hz;
      twice_r <= in_s.multiplier_select == pci_pkg::MULT_X2;
      rej_r   <= !(in_s.multiplier_select == pci_pkg::MULT_X1 ||
                   in_s.multiplier_select == pci_pkg::MULT_X2);
    end
  end

  pci_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (v1_r),
    .ready_o    (rdy1),
    .freq_i     (freq_r),
    .twice_i    (twice_r),
    .rejected_i (rej_r),
    .valid_o    (v2),
    .ready_i    (rdy2),
    .data_o     (interp)
  );

  pci_round_div u_round_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (v2),
    .ready_o (rdy2),
    .data_i  (interp),
    .valid_o (out_s.valid),
    .ready_i (out_s.ready),
    .data_o  (result)
  );

  assign out_s.correction_mdeg = result.correction_mdeg;
  assign out_s.rejected        = result.rejected;

endmodule

// ===== hw/rtl/pci_checker.sv =====
// Port-level checks for the phase correction interpolator, bound to the top level.
// Depends on pci_pkg for the field widths.
module pci_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pci_pkg::CORR_W-1:0] out_correction_mdeg,
  input logic                              out_rejected
);

  localparam logic signed [pci_pkg::CORR_W-1:0] CORR_LOW  = -14'sd130;
  localparam logic signed [pci_pkg::CORR_W-1:0] CORR_HIGH = 14'sd5240;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_correction_mdeg == '0)
    else $error("Rejected beat carries a nonzero correction.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rejected |->
      out_correction_mdeg >= CORR_LOW && out_correction_mdeg <= CORR_HIGH)
    else $error("Correction lies outside the calibration range.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_correction_mdeg) && $stable(out_rejected))
    else $error("Stalled result beat changed or dropped.");

endmodule

bind phase_correction_interpolator pci_checker u_pci_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_s.valid),
  .out_ready           (out_s.ready),
  .out_correction_mdeg (out_s.correction_mdeg),
  .out_rejected        (out_s.rejected)
);
